### src/mpq_pkg.sv
// Package with the request codes, status codes and cell control type of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic                     en;
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

### src/mpq_if.sv
// Interfaces for the request and result channels of the priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface mpq_req_if;
  logic                valid;
  logic                ready;
  mpq_pkg::kind_t      kind;
  logic signed [31:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface mpq_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  removed_value;
  logic signed [31:0]  head_value;
  logic                is_empty;
  logic [4:0]          entry_count;
  mpq_pkg::status_t    status;

  modport source (output valid, output removed_value, output head_value, output is_empty,
                  output entry_count, output status, input ready);
  modport sink (input valid, input removed_value, input head_value, input is_empty,
                input entry_count, input status, output ready);
endinterface
`default_nettype wire

### src/min_priority_queue_top.sv
// Top level of the min-priority queue built as a chain of sorted cells.
//
//   channel  direction  payload
//   req      in         kind, value
//   rsp      out        removed_value, head_value, is_empty, entry_count, status
//
// On each request all cells compare against the new value and shift together, so the
// cell compare-and-select path sets the clock period. A request is taken whenever
// the result register is empty or its item is being taken in the same cycle.
// Synchronous reset empties the queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module min_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  mpq_req_if.sink     req,
  mpq_rsp_if.source   rsp
);
  import mpq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               full;
  logic               empty;
  kind_t              eff_kind;
  status_t            status_next;
  cell_ctl_t          ctl;

  logic signed [31:0] cell_data [CAPACITY];
  logic signed [31:0] cell_next [CAPACITY];
  logic               cell_le   [CAPACITY];

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    eff_kind    = KIND_STATUS;
    status_next = ST_OK;
    count_next  = count;
    case (req.kind)
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          eff_kind   = KIND_INSERT;
          count_next = count + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          eff_kind   = KIND_REMOVE;
          count_next = count - CW'(1);
        end
      end
      KIND_CLEAR: count_next = '0;
      default:    count_next = count;
    endcase
  end

  assign ctl.en    = accept && ((eff_kind == KIND_INSERT) || (eff_kind == KIND_REMOVE));
  assign ctl.kind  = eff_kind;
  assign ctl.value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_le;
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;

    if (i == 0) begin : g_first
      assign left_le   = 1'b1;
      assign left_data = cell_data[0];
    end else begin : g_mid
      assign left_le   = cell_le[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count > CW'(i)),
      .left_le    (left_le),
      .left_data  (left_data),
      .right_data (right_data),
      .le         (cell_le[i]),
      .data       (cell_data[i]),
      .data_next  (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.removed_value <= (eff_kind == KIND_REMOVE) ? cell_data[0] : '0;
      rsp.head_value    <= (count_next != '0) ? cell_next[0] : '0;
      rsp.is_empty      <= (count_next == '0);
      rsp.entry_count   <= COUNT_W'(count_next);
      rsp.status        <= status_next;
    end
  end

endmodule
`default_nettype wire

### src/mpq_cell.sv
// One slot of the sorted chain: holds a value and shifts it toward either neighbor.
`timescale 1ns / 1ps
`default_nettype none
module mpq_cell (
  input  wire                    clk,
  input  wire mpq_pkg::cell_ctl_t ctl,
  input  wire                    occupied,
  input  wire                    left_le,
  input  wire signed [31:0]      left_data,
  input  wire signed [31:0]      right_data,
  output logic                   le,
  output logic signed [31:0]     data,
  output logic signed [31:0]     data_next
);
  import mpq_pkg::*;

  assign le = occupied && (data <= ctl.value);

  always_comb begin
    case (ctl.kind)
      KIND_INSERT: begin
        if (le) begin
          data_next = data;
        end else if (left_le) begin
          data_next = ctl.value;
        end else begin
          data_next = left_data;
        end
      end
      KIND_REMOVE: data_next = right_data;
      default:     data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire
